// ===== design/ffa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int ADDR_W          = 16;
  localparam int DEF_HEAP_BYTES  = 64 * 1024;
  localparam int DEF_HEADER      = 8;
  localparam int DEF_ALIGN       = 8;
  localparam int DEF_SLACK       = 16;
  localparam int RECIP_SHIFT     = 20;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_NOOP = 2'd2;

  localparam logic REG_HEAP_LIMIT = 1'b0;

  typedef struct packed {
    logic [ADDR_W-1:0] size;
    logic              used;
    logic [ADDR_W-1:0] next;
  } header_t;

  // log2 of the largest power of two, up to 16, dividing every block start
  function automatic int gran_log(input int hdr, input int aln);
    int v;
    int r;
    v = hdr | aln;
    r = 0;
    for (int i = 0; i < 5; i++) begin
      if (((v >> i) << i) == v) r = i;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/ffa_hdr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_hdr_ram
// Header store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffa_hdr_ram
  import ffa_pkg::*;
#(
  parameter int IW = 13
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [IW-1:0] rd_idx,
  output header_t            rd_data,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_idx,
  input  wire header_t       wr_data
);

  header_t mem [1 << IW];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_idx];
  end

endmodule
`default_nettype wire

// ===== design/first_fit_heap_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit allocator over an address-ordered block list with coalescing.
//
//   channel   dir  handshake          payload
//   in        in   in_valid/in_ready  opcode, block_address, request_bytes
//   out       out  out_valid/out_ready result_address, status, copy_bytes
//   cfg       in   APB write/read     heap_limit at byte address 0
//
// One item at a time. An item goes through header reads (each header visited
// on a list walk and each look at the next block, with registered read
// data), header writes, and for a realloc of a found block a decide step;
// a moved realloc walks the list three times (find, allocate, free). After
// reset and after a heap_limit write the first header is written in S_FORM;
// no item is taken then. A new item is taken while a result waits on the
// output register.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit
  import ffa_pkg::*;
#(
  parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
  parameter int HEADER_BYTES = DEF_HEADER,
  parameter int ALIGN_BYTES  = DEF_ALIGN,
  parameter int SPLIT_SLACK  = DEF_SLACK
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] block_address,
  input  wire logic [16:0] request_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      result_address,
  output logic [1:0]       status,
  output logic [16:0]      copy_bytes,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int GL        = gran_log(HEADER_BYTES, ALIGN_BYTES);
  localparam int IW        = $clog2(HEAP_BYTES) - GL;
  localparam int MIN_SPLIT = HEADER_BYTES + SPLIT_SLACK;
  localparam int RECIP     = (1 << RECIP_SHIFT) / ALIGN_BYTES;
  localparam logic [15:0] HDR  = 16'(HEADER_BYTES);
  localparam logic [16:0] HEAP = 17'(HEAP_BYTES);

  typedef enum logic [3:0] {
    S_FORM, S_IDLE, S_AL, S_A_RD, S_A_CHK, S_F_RD, S_F_CHK, S_RA,
    S_N_RD, S_N_CHK, S_WS, S_WB, S_FR_WB, S_FR_PV, S_DONE
  } state_t;

  typedef enum logic [1:0] {NM_FREE, NM_SHRINK, NM_GROW} nmode_t;

  state_t      state;
  nmode_t      nmode;
  logic [16:0] heap_limit;
  logic [1:0]  op;
  logic [15:0] addr;
  logic [16:0] bytes;
  logic [15:0] target;
  logic [17:0] mreg, q0, req;
  logic        moved, pv_ok;
  logic [15:0] cur, pv, blk_old;
  header_t     hreg, pvh;
  logic [15:0] ws_size, ws_next, wb_size, wb_next;
  logic [15:0] res_addr;
  logic [1:0]  res_st;
  logic [16:0] res_copy;

  header_t     rd_data, wr_data;
  logic        rd_en, wr_en;
  logic [15:0] rd_byte, wr_byte, rd_sh, wr_sh;

  logic        cfg_wr, lim_wr;
  logic [17:0] m_in, prod, rem;
  logic [37:0] qprod;
  logic [15:0] s_addr, left, cap16;
  logic [16:0] cap, comb;
  logic [17:0] comb_left;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign lim_wr   = cfg_wr && (paddr[2] == REG_HEAP_LIMIT);
  assign prdata   = (paddr[2] == REG_HEAP_LIMIT) ? {15'd0, heap_limit} : 32'd0;
  assign in_ready = (state == S_IDLE);

  assign m_in   = 18'(request_bytes) + 18'(ALIGN_BYTES - 1);
  assign qprod  = 38'(m_in) * 38'(RECIP);
  assign prod   = 18'(q0 * 18'(ALIGN_BYTES));
  assign rem    = mreg - prod;
  assign s_addr = cur + HDR + req[15:0];
  assign left   = (state == S_RA) ? blk_old - req[15:0] : rd_data.size - req[15:0];
  assign comb   = 17'(blk_old) + 17'(HDR) + 17'(rd_data.size);
  assign comb_left = 18'(comb) - req;

  always_comb begin
    cap = HEAP;
    if (heap_limit != 17'd0 && heap_limit < HEAP) cap = heap_limit;
    if (cap < 17'(HDR)) cap = 17'(HDR);
    cap16 = 16'(cap - 17'(HDR));
  end

  function automatic logic link_ok(input logic [15:0] nx);
    return nx != 16'd0 && 17'(nx) < HEAP;
  endfunction

  function automatic logic walk_end(input logic [15:0] nx, input logic [15:0] c);
    return nx == 16'd0 || nx <= c || 17'(nx) >= HEAP;
  endfunction

  always_comb begin
    rd_en   = 1'b0;
    rd_byte = cur;
    wr_en   = 1'b0;
    wr_byte = cur;
    wr_data = '{size: wb_size, used: 1'b1, next: wb_next};
    case (state)
      S_A_RD, S_F_RD: rd_en = 1'b1;
      S_N_RD: begin
        rd_en   = 1'b1;
        rd_byte = hreg.next;
      end
      S_FORM: begin
        wr_en   = 1'b1;
        wr_byte = 16'd0;
        wr_data = '{size: cap16, used: 1'b0, next: 16'd0};
      end
      S_WS: begin
        wr_en   = 1'b1;
        wr_byte = s_addr;
        wr_data = '{size: ws_size, used: 1'b0, next: ws_next};
      end
      S_WB: wr_en = 1'b1;
      S_FR_WB: begin
        wr_en   = 1'b1;
        wr_data = '{size: hreg.size, used: 1'b0, next: hreg.next};
      end
      S_FR_PV: begin
        wr_en   = 1'b1;
        wr_byte = pv;
        wr_data = '{size: pvh.size + hreg.size + HDR, used: 1'b0, next: hreg.next};
      end
      default: ;
    endcase
    rd_sh = rd_byte >> GL;
    wr_sh = wr_byte >> GL;
  end

  ffa_hdr_ram #(.IW(IW)) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_idx  (rd_sh[IW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_idx  (wr_sh[IW-1:0]),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FORM;
      heap_limit <= 17'd0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE || lim_wr)) out_valid <= 1'b0;
      if (lim_wr) begin
        heap_limit <= pwdata[16:0];
        state      <= S_FORM;
      end else begin
        case (state)
          S_FORM: state <= S_IDLE;
          S_IDLE: begin
            if (in_valid) begin
              op     <= opcode;
              addr   <= block_address;
              bytes  <= request_bytes;
              target <= block_address - HDR;
              mreg   <= m_in;
              q0     <= qprod[RECIP_SHIFT +: 18];
              moved  <= 1'b0;
              pv_ok  <= 1'b0;
              cur    <= 16'd0;
              state  <= S_AL;
            end
          end
          S_AL: begin
            req <= (rem >= 18'(ALIGN_BYTES)) ? prod + 18'(ALIGN_BYTES) : prod;
            res_addr <= 16'd0;
            res_copy <= 17'd0;
            res_st   <= ST_NOOP;
            state    <= S_DONE;
            case (op)
              OP_ALLOC: if (bytes != 17'd0) state <= S_A_RD;
              OP_FREE:  if (addr >= HDR) state <= S_F_RD;
              OP_REALLOC: begin
                if (addr == 16'd0) begin
                  if (bytes != 17'd0) state <= S_A_RD;
                end else if (addr >= HDR) begin
                  state <= S_F_RD;
                end
              end
              default: ;
            endcase
          end
          S_A_RD: state <= S_A_CHK;
          S_A_CHK: begin
            if (!rd_data.used && 18'(rd_data.size) >= req) begin
              if (left >= 16'(MIN_SPLIT)) begin
                ws_size <= left - HDR;
                ws_next <= rd_data.next;
                wb_size <= req[15:0];
                wb_next <= s_addr;
                state   <= S_WS;
              end else begin
                wb_size <= rd_data.size;
                wb_next <= rd_data.next;
                state   <= S_WB;
              end
            end else if (walk_end(rd_data.next, cur)) begin
              res_addr <= 16'd0;
              res_copy <= 17'd0;
              res_st   <= ST_OOM;
              state    <= S_DONE;
            end else begin
              cur   <= rd_data.next;
              state <= S_A_RD;
            end
          end
          S_F_RD: state <= S_F_CHK;
          S_F_CHK: begin
            if (cur == target) begin
              if (!rd_data.used) begin
                state <= S_DONE;
                if (!moved) res_st <= ST_NOOP;
              end else begin
                hreg    <= rd_data;
                blk_old <= rd_data.size;
                if (op == OP_FREE || moved || bytes == 17'd0) begin
                  nmode <= NM_FREE;
                  state <= link_ok(rd_data.next) ? S_N_RD : S_FR_WB;
                end else begin
                  state <= S_RA;
                end
              end
            end else if (cur > target || walk_end(rd_data.next, cur)) begin
              state <= S_DONE;
              if (!moved) res_st <= ST_NOOP;
            end else begin
              pv    <= cur;
              pvh   <= rd_data;
              pv_ok <= 1'b1;
              cur   <= rd_data.next;
              state <= S_F_RD;
            end
          end
          S_RA: begin
            if (18'(blk_old) >= req) begin
              if (left >= 16'(MIN_SPLIT)) begin
                wb_size <= req[15:0];
                wb_next <= s_addr;
                nmode   <= NM_SHRINK;
                ws_size <= left - HDR;
                ws_next <= hreg.next;
                state   <= link_ok(hreg.next) ? S_N_RD : S_WS;
              end else begin
                res_addr <= addr;
                res_st   <= ST_DONE;
                state    <= S_DONE;
              end
            end else if (link_ok(hreg.next)) begin
              nmode <= NM_GROW;
              state <= S_N_RD;
            end else begin
              moved <= 1'b1;
              cur   <= 16'd0;
              state <= S_A_RD;
            end
          end
          S_N_RD: state <= S_N_CHK;
          S_N_CHK: begin
            case (nmode)
              NM_FREE: begin
                if (!rd_data.used) begin
                  hreg.size <= hreg.size + rd_data.size + HDR;
                  hreg.next <= rd_data.next;
                end
                state <= S_FR_WB;
              end
              NM_SHRINK: begin
                if (!rd_data.used) begin
                  ws_size <= blk_old + rd_data.size - req[15:0];
                  ws_next <= rd_data.next;
                end
                state <= S_WS;
              end
              default: begin
                if (!rd_data.used && 18'(comb) >= req) begin
                  if (comb_left >= 18'(MIN_SPLIT)) begin
                    ws_size <= blk_old + rd_data.size - req[15:0];
                    ws_next <= rd_data.next;
                    wb_size <= req[15:0];
                    wb_next <= s_addr;
                    state   <= S_WS;
                  end else begin
                    wb_size <= comb[15:0];
                    wb_next <= rd_data.next;
                    state   <= S_WB;
                  end
                end else begin
                  moved <= 1'b1;
                  cur   <= 16'd0;
                  state <= S_A_RD;
                end
              end
            endcase
          end
          S_WS: state <= S_WB;
          S_WB: begin
            res_addr <= cur + HDR;
            res_st   <= ST_DONE;
            if (moved) begin
              res_copy <= (17'(blk_old) < bytes) ? 17'(blk_old) : bytes;
              cur      <= 16'd0;
              pv_ok    <= 1'b0;
              state    <= S_F_RD;
            end else begin
              res_copy <= 17'd0;
              state    <= S_DONE;
            end
          end
          S_FR_WB: begin
            if (pv_ok && !pvh.used) begin
              state <= S_FR_PV;
            end else begin
              res_st <= ST_DONE;
              if (!moved) begin
                res_addr <= 16'd0;
                res_copy <= 17'd0;
              end
              state <= S_DONE;
            end
          end
          S_FR_PV: begin
            res_st <= ST_DONE;
            if (!moved) begin
              res_addr <= 16'd0;
              res_copy <= 17'd0;
            end
            state <= S_DONE;
          end
          S_DONE: begin
            if (!out_valid || out_ready) begin
              out_valid      <= 1'b1;
              result_address <= res_addr;
              status         <= res_st;
              copy_bytes     <= res_copy;
              state          <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in flight");

  a_oom_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OOM |-> result_address == 16'd0 && copy_bytes == 17'd0)
    else $error("failed request carries an address or copy length");

  a_copy_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && copy_bytes != 17'd0 |-> status == ST_DONE && result_address != 16'd0)
    else $error("copy length without a moved block");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_DONE || status == ST_OOM || status == ST_NOOP)
    else $error("undefined status code");

endmodule
`default_nettype wire

// ===== verif/first_fit_heap_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit_tb
// Self-checking bench for the first-fit heap allocator. A directed table, then
// random alloc/free/realloc traffic over several heap_limit settings. Every
// result is checked against an in-bench heap predictor (typed table rows
// against their own values), with random stalls on both channels.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit_tb;
  import ffa_pkg::*;

  localparam int unsigned HB    = DEF_HEAP_BYTES;
  localparam int unsigned HDR   = DEF_HEADER;
  localparam int unsigned ALN   = DEF_ALIGN;
  localparam int unsigned MINSP = DEF_HEADER + DEF_SLACK;
  localparam int unsigned NOBLK = 32'hFFFF_FFFF;
  localparam logic [1:0]  OP_NONE = 2'd3;

  typedef struct {
    logic [15:0] ra;
    logic [1:0]  st;
    logic [16:0] cb;
  } alloc_result_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [16:0] bytes;
    bit          typed;
    logic [15:0] ra;
    logic [1:0]  st;
    logic [16:0] cb;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [15:0] block_address = '0;
  logic [16:0] request_bytes = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] result_address;
  logic [1:0]  status;
  logic [16:0] copy_bytes;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  first_fit_heap_allocator_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .block_address(block_address), .request_bytes(request_bytes),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_address(result_address), .status(status), .copy_bytes(copy_bytes),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  int unsigned   hsz [HB];
  int unsigned   hnx [HB];
  bit            hus [HB];
  int unsigned   heap_lim;
  alloc_result_t pending_q[$];
  int unsigned   live_addrs[$];
  int            mismatches;
  int            checked;
  int            n_alloc, n_free, n_realloc, n_other;
  bit            calm;
  bit            hold_req;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---- heap predictor ----
  function automatic void heap_reform();
    int unsigned cap;
    cap = HB;
    if (heap_lim != 0 && heap_lim < cap) cap = heap_lim;
    if (cap < HDR) cap = HDR;
    for (int i = 0; i < HB; i++) begin
      hsz[i] = 0;
      hnx[i] = 0;
      hus[i] = 0;
    end
    hsz[0] = cap - HDR;
  endfunction

  function automatic int unsigned round_up(int unsigned n);
    return ((n + ALN - 1) / ALN) * ALN;
  endfunction

  function automatic void carve(int unsigned b, int unsigned req, int unsigned left,
                                int unsigned after);
    int unsigned s;
    s = b + HDR + req;
    if (s >= HB) return;
    hsz[s] = left - HDR;
    hus[s] = 0;
    hnx[s] = after;
    hsz[b] = req;
    hnx[b] = s;
  endfunction

  function automatic logic [1:0] first_fit(int unsigned bytes, output int unsigned addr);
    int unsigned req;
    int unsigned cur;
    int unsigned left;
    addr = 0;
    cur = 0;
    if (bytes == 0) return ST_NOOP;
    req = round_up(bytes);
    forever begin
      if (!hus[cur] && hsz[cur] >= req) begin
        left = hsz[cur] - req;
        if (left >= MINSP) carve(cur, req, left, hnx[cur]);
        hus[cur] = 1;
        addr = cur + HDR;
        return ST_DONE;
      end
      if (hnx[cur] == 0 || hnx[cur] <= cur || hnx[cur] >= HB) return ST_OOM;
      cur = hnx[cur];
    end
  endfunction

  function automatic bit locate_used(int unsigned addr, output int unsigned blk,
                                     output int unsigned prev);
    int unsigned cur;
    int unsigned target;
    cur = 0;
    prev = NOBLK;
    blk = 0;
    if (addr < HDR) return 0;
    target = addr - HDR;
    forever begin
      if (cur == target) begin
        blk = cur;
        return hus[cur];
      end
      if (cur > target) return 0;
      if (hnx[cur] == 0 || hnx[cur] <= cur || hnx[cur] >= HB) return 0;
      prev = cur;
      cur = hnx[cur];
    end
  endfunction

  function automatic void release_blk(int unsigned b, int unsigned prev);
    int unsigned n;
    n = hnx[b];
    hus[b] = 0;
    if (n != 0 && n < HB && !hus[n]) begin
      hsz[b] += hsz[n] + HDR;
      hnx[b] = hnx[n];
    end
    if (prev != NOBLK && !hus[prev]) begin
      hsz[prev] += hsz[b] + HDR;
      hnx[prev] = hnx[b];
    end
  endfunction

  function automatic logic [1:0] resize(int unsigned addr, int unsigned bytes,
                                        output int unsigned res, output int unsigned cpy);
    int unsigned b, prev, old, req, n, comb, left, s, after, naddr;
    res = 0;
    cpy = 0;
    if (addr == 0) return first_fit(bytes, res);
    if (!locate_used(addr, b, prev)) return ST_NOOP;
    if (bytes == 0) begin
      release_blk(b, prev);
      return ST_DONE;
    end
    old = hsz[b];
    req = round_up(bytes);
    if (req <= old) begin
      left = old - req;
      if (left >= MINSP) begin
        carve(b, req, left, hnx[b]);
        s = hnx[b];
        if (s != 0 && s < HB && s != b) begin
          after = hnx[s];
          if (after != 0 && after < HB && !hus[after]) begin
            hsz[s] += hsz[after] + HDR;
            hnx[s] = hnx[after];
          end
        end
      end
      res = addr;
      return ST_DONE;
    end
    n = hnx[b];
    if (n != 0 && n < HB && !hus[n]) begin
      comb = old + HDR + hsz[n];
      if (comb >= req) begin
        left = comb - req;
        if (left >= MINSP) carve(b, req, left, hnx[n]);
        else begin
          hsz[b] = comb;
          hnx[b] = hnx[n];
        end
        res = addr;
        return ST_DONE;
      end
    end
    if (first_fit(bytes, naddr) != ST_DONE) return ST_OOM;
    cpy = (old < bytes) ? old : bytes;
    if (locate_used(addr, b, prev)) release_blk(b, prev);
    res = naddr;
    return ST_DONE;
  endfunction

  function automatic void drop_live(int unsigned a);
    foreach (live_addrs[i]) begin
      if (live_addrs[i] == a) begin
        live_addrs.delete(i);
        return;
      end
    end
  endfunction

  function automatic alloc_result_t predict_item(logic [1:0] op, logic [15:0] addr,
                                                 logic [16:0] bytes);
    alloc_result_t r;
    int unsigned res, cpy, b, prev;
    logic [1:0] st;
    res = 0;
    cpy = 0;
    st = ST_NOOP;
    case (op)
      OP_ALLOC: begin
        st = first_fit(bytes, res);
        if (st == ST_DONE) live_addrs.push_back(res);
      end
      OP_FREE: begin
        if (addr != 0 && locate_used(addr, b, prev)) begin
          release_blk(b, prev);
          st = ST_DONE;
          drop_live(addr);
        end
      end
      OP_REALLOC: begin
        st = resize(addr, bytes, res, cpy);
        if (st == ST_DONE) begin
          if (addr != 0) drop_live(addr);
          if (res != 0) live_addrs.push_back(res);
        end
      end
      default: st = ST_NOOP;
    endcase
    r.ra = res[15:0];
    r.st = st;
    r.cb = cpy[16:0];
    return r;
  endfunction

  // ---- channel drivers ----
  task automatic send_item(logic [1:0] op, logic [15:0] addr, logic [16:0] bytes,
                           alloc_result_t want);
    in_valid      <= 1'b1;
    opcode        <= op;
    block_address <= addr;
    request_bytes <= bytes;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(want);
    case (op)
      OP_ALLOC:   n_alloc++;
      OP_FREE:    n_free++;
      OP_REALLOC: n_realloc++;
      default:    n_other++;
    endcase
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    heap_lim = v & 32'h1FFFF;
    heap_reform();
    live_addrs.delete();
  endtask

  task automatic random_item();
    int unsigned r;
    logic [1:0]  op;
    logic [15:0] addr;
    logic [16:0] bytes;
    r = $urandom_range(0, 99);
    addr = '0;
    bytes = 17'($urandom_range(1, 256));
    if ($urandom_range(0, 19) == 0) bytes = 17'($urandom_range(0, 65536));
    if (live_addrs.size() > 48 && r < 40) r = 50;
    if (r < 40) op = OP_ALLOC;
    else if (r < 65) begin
      op = OP_FREE;
      if (live_addrs.size() != 0)
        addr = 16'(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
    end else if (r < 85) begin
      op = OP_REALLOC;
      if ($urandom_range(0, 9) == 0) bytes = '0;
      if (live_addrs.size() != 0)
        addr = 16'(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
    end else if (r < 90) begin
      op = OP_REALLOC;
    end else if (r < 96) begin
      op = ($urandom_range(0, 1) != 0) ? OP_FREE : OP_REALLOC;
      addr = 16'($urandom_range(0, 65535));
    end else begin
      op = OP_NONE;
      addr = 16'($urandom_range(0, 65535));
      bytes = 17'($urandom_range(0, 131071));
    end
    send_item(op, addr, bytes, predict_item(op, addr, bytes));
  endtask

  // ---- receiver ----
  initial begin
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---- result check ----
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result addr=%0d st=%0d copy=%0d",
                                       result_address, status, copy_bytes);
      end else begin
        alloc_result_t w;
        w = pending_q.pop_front();
        checked++;
        if (result_address !== w.ra || status !== w.st || copy_bytes !== w.cb) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected addr=%0d st=%0d copy=%0d, got addr=%0d st=%0d copy=%0d",
                     checked, w.ra, w.st, w.cb, result_address, status, copy_bytes);
        end
      end
    end
  end

  // ---- stimulus ----
  dir_row_t dir_rows[] = '{
    '{OP_ALLOC,   16'd0,      17'd0,     1, 16'd0,  ST_NOOP, 17'd0},
    '{OP_ALLOC,   16'd0,      17'd65536, 1, 16'd0,  ST_OOM,  17'd0},
    '{OP_ALLOC,   16'd0,      17'd1,     1, 16'd8,  ST_DONE, 17'd0},
    '{OP_ALLOC,   16'd0,      17'd17,    1, 16'd24, ST_DONE, 17'd0},
    '{OP_FREE,    16'd0,      17'd0,     1, 16'd0,  ST_NOOP, 17'd0},
    '{OP_FREE,    16'd12,     17'd0,     1, 16'd0,  ST_NOOP, 17'd0},
    '{OP_NONE,    16'hFFFF,   17'h1FFFF, 1, 16'd0,  ST_NOOP, 17'd0},
    '{OP_REALLOC, 16'hFFFF,   17'd1,     1, 16'd0,  ST_NOOP, 17'd0},
    '{OP_REALLOC, 16'd0,      17'd5,     0, 16'd0,  ST_DONE, 17'd0},
    '{OP_REALLOC, 16'd8,      17'd100,   0, 16'd0,  ST_DONE, 17'd0},
    '{OP_ALLOC,   16'd0,      17'd200,   0, 16'd0,  ST_DONE, 17'd0},
    '{OP_REALLOC, 16'd24,     17'd8,     0, 16'd0,  ST_DONE, 17'd0},
    '{OP_REALLOC, 16'd24,     17'd40,    0, 16'd0,  ST_DONE, 17'd0},
    '{OP_REALLOC, 16'd24,     17'd65536, 0, 16'd0,  ST_OOM,  17'd0},
    '{OP_FREE,    16'd24,     17'd0,     0, 16'd0,  ST_DONE, 17'd0},
    '{OP_FREE,    16'd24,     17'd0,     0, 16'd0,  ST_NOOP, 17'd0},
    '{OP_REALLOC, 16'd48,     17'd0,     0, 16'd0,  ST_DONE, 17'd0},
    '{OP_ALLOC,   16'd0,      17'd65000, 0, 16'd0,  ST_DONE, 17'd0},
    '{OP_ALLOC,   16'd0,      17'd1000,  0, 16'd0,  ST_OOM,  17'd0},
    '{OP_REALLOC, 16'd0,      17'd0,     0, 16'd0,  ST_NOOP, 17'd0}
  };
  logic [31:0] limits[] = '{32'd1024, 32'd8, 32'd65536, 32'd3, 32'h1FFFF, 32'd4096, 32'd0};

  initial begin
    alloc_result_t w;
    heap_lim = 0;
    heap_reform();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      w = predict_item(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].bytes);
      if (dir_rows[i].typed) begin
        w.ra = dir_rows[i].ra;
        w.st = dir_rows[i].st;
        w.cb = dir_rows[i].cb;
      end
      send_item(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].bytes, w);
    end
    drain();
    foreach (limits[p]) begin
      write_limit(limits[p]);
      for (int k = 0; k < 225; k++) begin
        if (p == 1 && k == 10) hold_req = 1'b1;
        if (k == 110) drain();
        if (p == limits.size() - 1 && k == 100) calm = 1'b1;
        random_item();
      end
      drain();
    end
    repeat (50) @(posedge clk);
    $display("covered %0d alloc, %0d free, %0d realloc, %0d other items over %0d heap limits",
             n_alloc, n_free, n_realloc, n_other, limits.size() + 1);
    $display("%0d results checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
